>>> sv/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

    // overlap threshold register, unsigned Q0.16
    localparam int              THRESH_W     = 16;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd26214;   // 0.4

    // width of the reported position within a frame
    localparam int              ITEM_INDEX_W = 12;

    // status of the overlap compare pipeline, seen by the controller
    typedef struct packed {
        logic busy;      // any stage holds a comparison
        logic hit_vld;   // a comparison result is out this cycle
        logic hit;       // that comparison exceeds the threshold
    } t_cmp_status;

endpackage

>>> sv/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy non-maximum suppression by intersection over union, one candidate
// at a time, kept boxes held in an on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (i_valid/o_ready) takes one candidate box per transaction,
//   sorted by descending score within a frame; i_last_in_frame ends a frame.
// - Output channel (o_valid/i_ready) gives one result per candidate: keep,
//   item_index, store_full, frame_done, in input order.
// - Config channel (i_cfg_valid/o_cfg_ready) writes the Q0.16 IoU threshold;
//   write it only while the block is idle.
// - Each candidate is checked against every box kept so far in the frame,
//   one memory read per cycle feeding a five-stage compare pipeline. The
//   block is ready for the next candidate in the same cycle that the result
//   is registered; the scan stops early on a hit.
//   The kept-box memory read port sets the rate: one comparison per cycle.
// - One candidate is in work at a time. The result sits in an output
//   register, so the next candidate is accepted while it waits; a stalled
//   receiver holds the block only when a second result is ready.
// - Reset sets the threshold to 0.4, empties the store and zeroes the item
//   index. The memory needs no clearing: only written entries are read.
// ----------------------------------------------------------------------------
module greedy_box_suppression #(
    parameter int MAX_KEPT   = 64,
    parameter int COORD_BITS = 16,
    parameter int MAX_ITEMS  = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gbs_pkg::THRESH_W-1:0]          i_cfg_data,
    // candidate input
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [COORD_BITS-1:0]          i_box_left,
    input  logic signed [COORD_BITS-1:0]          i_box_top,
    input  logic [COORD_BITS-2:0]                 i_box_width,
    input  logic [COORD_BITS-2:0]                 i_box_height,
    input  logic                                  i_last_in_frame,
    // result output
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_keep,
    output logic [gbs_pkg::ITEM_INDEX_W-1:0]      o_item_index,
    output logic                                  o_store_full,
    output logic                                  o_frame_done
);
    import gbs_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int IDX_XW = (IDX_W > ITEM_INDEX_W) ? IDX_W : ITEM_INDEX_W;
    localparam int BOX_W  = 4 * CB - 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [THRESH_W-1:0]   r_thresh;
    logic signed [CB-1:0]  r_cand_left, r_cand_top;
    logic [CB-2:0]         r_cand_width, r_cand_height;
    logic                  r_cand_last;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_rd_cnt;
    logic [IDX_W-1:0]      r_item_cnt;
    logic                  r_rd_vld;
    logic                  r_hit;
    logic                  r_out_valid, r_out_keep, r_out_full, r_out_last;
    logic [ITEM_INDEX_W-1:0] r_out_index;

    logic [BOX_W-1:0]      r_mem [MAX_KEPT];
    logic [BOX_W-1:0]      r_rd_data;

    t_cmp_status           cmp_stat;
    logic                  rd_en, scan_last, store_full, out_free, finish, mem_we;
    logic [IDX_XW-1:0]     idx_ext;

    // control decodes
    assign rd_en      = (r_state == S_SCAN);
    assign scan_last  = ((r_rd_cnt + CNT_W'(1)) == r_count);
    assign store_full = (r_count == CNT_W'(MAX_KEPT));
    assign out_free   = !r_out_valid || i_ready;
    assign finish     = (r_state == S_FINISH) && out_free;
    assign mem_we     = finish && !r_hit && !store_full;
    assign idx_ext    = IDX_XW'(r_item_cnt);

    // kept-box memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[ADDR_W-1:0]] <= {r_cand_left, r_cand_top,
                                           r_cand_width, r_cand_height};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_cnt[ADDR_W-1:0]];
        end
    end

    // sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thresh    <= THRESH_RESET;
            r_count     <= '0;
            r_rd_cnt    <= '0;
            r_item_cnt  <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_data;
            end
            // a new result loaded this cycle takes priority over the drain
            if (r_out_valid && i_ready && !finish) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld <= rd_en;
            if (cmp_stat.hit_vld && cmp_stat.hit) begin
                r_hit <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cand_left   <= i_box_left;
                        r_cand_top    <= i_box_top;
                        r_cand_width  <= i_box_width;
                        r_cand_height <= i_box_height;
                        r_cand_last   <= i_last_in_frame;
                        r_hit         <= 1'b0;
                        r_rd_cnt      <= '0;
                        r_state       <= (r_count == '0) ? S_WAIT : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue one read per cycle; stop early once a hit is seen
                    r_rd_cnt <= r_rd_cnt + CNT_W'(1);
                    if (scan_last || r_hit) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    // drain reads and compares in flight
                    if (!r_rd_vld && !cmp_stat.busy) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_keep  <= !r_hit;
                        r_out_full  <= !r_hit && store_full;
                        r_out_last  <= r_cand_last;
                        r_out_index <= idx_ext[ITEM_INDEX_W-1:0];
                        if (r_cand_last) begin
                            r_count    <= '0;
                            r_item_cnt <= '0;
                        end else begin
                            if (!r_hit && !store_full) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            if (r_item_cnt == IDX_W'(MAX_ITEMS - 1)) begin
                                r_item_cnt <= '0;
                            end else begin
                                r_item_cnt <= r_item_cnt + IDX_W'(1);
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // overlap compare pipeline
    gbs_iou_cmp #(
        .COORD_BITS (COORD_BITS)
    ) u_cmp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (r_rd_vld),
        .i_thresh      (r_thresh),
        .i_cand_left   (r_cand_left),
        .i_cand_top    (r_cand_top),
        .i_cand_width  (r_cand_width),
        .i_cand_height (r_cand_height),
        .i_kept_left   (r_rd_data[BOX_W-1 -: CB]),
        .i_kept_top    (r_rd_data[BOX_W-CB-1 -: CB]),
        .i_kept_width  (r_rd_data[2*CB-3 -: CB-1]),
        .i_kept_height (r_rd_data[CB-2:0]),
        .o_stat        (cmp_stat)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_keep       = r_out_keep;
    assign o_item_index = r_out_index;
    assign o_store_full = r_out_full;
    assign o_frame_done = r_out_last;

endmodule

>>> sv/gbs_iou_cmp.sv
// ----------------------------------------------------------------------------
// gbs_iou_cmp
// Five-stage pipeline that tests one candidate/kept box pair per cycle:
// intersection * 2^16 > threshold * union, without any division.
// ----------------------------------------------------------------------------
module gbs_iou_cmp #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  logic [gbs_pkg::THRESH_W-1:0]          i_thresh,
    input  logic signed [COORD_BITS-1:0]          i_cand_left,
    input  logic signed [COORD_BITS-1:0]          i_cand_top,
    input  logic [COORD_BITS-2:0]                 i_cand_width,
    input  logic [COORD_BITS-2:0]                 i_cand_height,
    input  logic signed [COORD_BITS-1:0]          i_kept_left,
    input  logic signed [COORD_BITS-1:0]          i_kept_top,
    input  logic [COORD_BITS-2:0]                 i_kept_width,
    input  logic [COORD_BITS-2:0]                 i_kept_height,
    output gbs_pkg::t_cmp_status                  o_stat
);
    import gbs_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int AREA_W = 2 * CB - 2;
    localparam int UNI_W  = AREA_W + 1;
    localparam int PROD_W = UNI_W + THRESH_W;

    // stage 1: overlap spans
    logic signed [CB-1:0] lmax, tmax;
    logic signed [CB:0]   rc, rk, bc, bk, rmin, bmin;
    logic signed [CB+1:0] spx, spy;
    logic                 pos_x, pos_y;

    always_comb begin
        lmax  = (i_cand_left > i_kept_left) ? i_cand_left : i_kept_left;
        tmax  = (i_cand_top  > i_kept_top)  ? i_cand_top  : i_kept_top;
        rc    = {i_cand_left[CB-1], i_cand_left} + {2'b00, i_cand_width};
        rk    = {i_kept_left[CB-1], i_kept_left} + {2'b00, i_kept_width};
        bc    = {i_cand_top[CB-1],  i_cand_top}  + {2'b00, i_cand_height};
        bk    = {i_kept_top[CB-1],  i_kept_top}  + {2'b00, i_kept_height};
        rmin  = (rc < rk) ? rc : rk;
        bmin  = (bc < bk) ? bc : bk;
        spx   = {rmin[CB], rmin} - {{2{lmax[CB-1]}}, lmax};
        spy   = {bmin[CB], bmin} - {{2{tmax[CB-1]}}, tmax};
        pos_x = !spx[CB+1] && (spx != '0);
        pos_y = !spy[CB+1] && (spy != '0);
    end

    logic              r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic [CB-2:0]     r1_sx, r1_sy, r1_kw, r1_kh;
    logic [AREA_W-1:0] r2_inter, r2_ak, r2_ac, r3_inter;
    logic [UNI_W-1:0]  r3_union;
    logic [PROD_W-1:0] r4_prod, r4_lhs;
    logic              r5_hit;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        // spans are never wider than the narrower box, so CB-1 bits hold them
        r1_sx    <= (pos_x && pos_y) ? spx[CB-2:0] : '0;
        r1_sy    <= (pos_x && pos_y) ? spy[CB-2:0] : '0;
        r1_kw    <= i_kept_width;
        r1_kh    <= i_kept_height;
        // areas
        r2_inter <= r1_sx * r1_sy;
        r2_ak    <= r1_kw * r1_kh;
        r2_ac    <= i_cand_width * i_cand_height;
        // union never goes negative: intersection is within either area
        r3_union <= UNI_W'(r2_ac) + UNI_W'(r2_ak) - UNI_W'(r2_inter);
        r3_inter <= r2_inter;
        // threshold scaling
        r4_prod  <= i_thresh * r3_union;
        r4_lhs   <= PROD_W'({r3_inter, {THRESH_W{1'b0}}});
        // final compare
        r5_hit   <= r4_lhs > r4_prod;
    end

    assign o_stat.busy    = r1_vld | r2_vld | r3_vld | r4_vld | r5_vld;
    assign o_stat.hit_vld = r5_vld;
    assign o_stat.hit     = r5_hit;

endmodule

>>> sv/gbs_checker.sv
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks for greedy_box_suppression, bound to the top level.
// ----------------------------------------------------------------------------
module gbs_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_ready,
    input logic signed [COORD_BITS-1:0]          i_box_left,
    input logic signed [COORD_BITS-1:0]          i_box_top,
    input logic [COORD_BITS-2:0]                 i_box_width,
    input logic [COORD_BITS-2:0]                 i_box_height,
    input logic                                  i_last_in_frame,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic                                  o_keep,
    input logic [gbs_pkg::ITEM_INDEX_W-1:0]      o_item_index,
    input logic                                  o_store_full,
    input logic                                  o_frame_done
);

    // a waiting candidate holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_box_left) &&
                                $stable(i_box_top) && $stable(i_box_width) &&
                                $stable(i_box_height) && $stable(i_last_in_frame))
        else $error("candidate changed while waiting");

    // a stalled result holds its item index, keep and frame-done fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item_index) &&
                                $stable(o_keep) && $stable(o_frame_done))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a full store only ever applies to a kept box
    a_full_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_store_full || o_keep)
        else $error("store_full on a dropped box");

    // one candidate in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second candidate accepted during a scan");

endmodule

bind greedy_box_suppression gbs_checker #(
    .COORD_BITS (COORD_BITS)
) u_gbs_checker (.*);

>>> verif/greedy_box_suppression_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_box_suppression testbench
// Drives candidate boxes through the suppression block and checks every
// keep/drop verdict, item index, store-full flag and frame mark against an
// in-bench prediction of the IoU test. Covers edge boxes, threshold extremes,
// a full kept store and random clustered frames with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module testbench;
    import gbs_pkg::*;

    localparam int MAX_KEPT   = 64;
    localparam int COORD_BITS = 16;
    localparam int MAX_ITEMS  = 4096;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;     // signed Q12.4
        logic [COORD_BITS-1:0] top;      // signed Q12.4
        logic [COORD_BITS-2:0] w;        // unsigned Q11.4
        logic [COORD_BITS-2:0] h;        // unsigned Q11.4
    } cand_box_t;

    typedef struct packed {
        logic                    keep;
        logic [ITEM_INDEX_W-1:0] index;
        logic                    full;
        logic                    done;
    } verdict_t;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [THRESH_W-1:0]          i_cfg_data;
    logic                         i_valid;
    logic                         o_ready;
    logic signed [COORD_BITS-1:0] i_box_left;
    logic signed [COORD_BITS-1:0] i_box_top;
    logic [COORD_BITS-2:0]        i_box_width;
    logic [COORD_BITS-2:0]        i_box_height;
    logic                         i_last_in_frame;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_keep;
    logic [ITEM_INDEX_W-1:0]      o_item_index;
    logic                         o_store_full;
    logic                         o_frame_done;

    // suppression state mirrored by the bench
    cand_box_t           kept_store [MAX_KEPT];
    int                  kept_n;
    int                  cand_no;
    logic [THRESH_W-1:0] thresh_q16;

    verdict_t verdict_q [$];
    bit       idling;
    int       errors;
    int       items_sent;
    int       n_kept, n_dropped, n_full, n_frames;
    int       stall_left;

    greedy_box_suppression #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS),
        .MAX_ITEMS  (MAX_ITEMS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_box_left      (i_box_left),
        .i_box_top       (i_box_top),
        .i_box_width     (i_box_width),
        .i_box_height    (i_box_height),
        .i_last_in_frame (i_last_in_frame),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_keep          (o_keep),
        .o_item_index    (o_item_index),
        .o_store_full    (o_store_full),
        .o_frame_done    (o_frame_done)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic cand_box_t mk_box(int l, int t, int w, int h);
        cand_box_t b;
        b.left = l[COORD_BITS-1:0];
        b.top  = t[COORD_BITS-1:0];
        b.w    = w[COORD_BITS-2:0];
        b.h    = h[COORD_BITS-2:0];
        return b;
    endfunction

    // overlap area in Q22.8, zero when the spans do not meet
    function automatic longint unsigned overlap_area(cand_box_t a, cand_box_t b);
        longint al, at, ar, ab, bl, bt, br, bb, l, t, r, btm;
        al  = longint'($signed(a.left));
        at  = longint'($signed(a.top));
        bl  = longint'($signed(b.left));
        bt  = longint'($signed(b.top));
        ar  = al + longint'(a.w);
        ab  = at + longint'(a.h);
        br  = bl + longint'(b.w);
        bb  = bt + longint'(b.h);
        l   = (al > bl) ? al : bl;
        t   = (at > bt) ? at : bt;
        r   = (ar < br) ? ar : br;
        btm = (ab < bb) ? ab : bb;
        if (r <= l || btm <= t)
            return 0;
        return longint'(unsigned'(r - l)) * longint'(unsigned'(btm - t));
    endfunction

    function automatic longint unsigned box_area(cand_box_t b);
        longint unsigned a;
        a = longint'(b.w);
        return a * longint'(b.h);
    endfunction

    // one candidate through the greedy IoU test, state updated in place
    function automatic verdict_t judge_candidate(cand_box_t c, logic last);
        verdict_t        v;
        longint unsigned inter, uni, thr;
        bit              survive;
        survive = 1'b1;
        thr     = longint'(thresh_q16);
        for (int i = 0; i < kept_n && survive; i++) begin
            inter = overlap_area(c, kept_store[i]);
            uni   = box_area(c) + box_area(kept_store[i]) - inter;
            if ((inter << 16) > thr * uni)
                survive = 1'b0;
        end
        v.keep  = survive;
        v.full  = 1'b0;
        v.index = cand_no[ITEM_INDEX_W-1:0];
        v.done  = last;
        if (survive) begin
            if (kept_n < MAX_KEPT) begin
                kept_store[kept_n] = c;
                kept_n++;
            end else begin
                v.full = 1'b1;
            end
        end
        if (last) begin
            kept_n  = 0;
            cand_no = 0;
        end else begin
            cand_no = (cand_no == MAX_ITEMS - 1) ? 0 : cand_no + 1;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        verdict_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t ns: result with nothing pending, keep=%0b index=%0d", $time,
                         o_keep, o_item_index);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                check_field("keep", 32'(want.keep), 32'(o_keep));
                check_field("item_index", 32'(want.index), 32'(o_item_index));
                check_field("store_full", 32'(want.full), 32'(o_store_full));
                check_field("frame_done", 32'(want.done), 32'(o_frame_done));
                if (want.keep) n_kept++;
                else n_dropped++;
                if (want.full) n_full++;
                if (want.done) n_frames++;
            end
        end
    end

    // receiver stalls in random bursts, started only while idling is set
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------
    task automatic send_box(input cand_box_t b, input logic last);
        int gap;
        gap = 0;
        if (idling && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_box_left      <= b.left;
        i_box_top       <= b.top;
        i_box_width     <= b.w;
        i_box_height    <= b.h;
        i_last_in_frame <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        verdict_q.insert(verdict_q.size(), judge_candidate(b, last));
        items_sent++;
    endtask

    // hold off the sender until every pending verdict is back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] thr);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        thresh_q16 = thr;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset threshold: edge coordinates, empty boxes, touching and near-0.4 overlaps
    task automatic test_edge_boxes();
        send_box(mk_box(0, 0, 160, 160), 1'b0);
        send_box(mk_box(0, 0, 160, 160), 1'b0);                 // duplicate
        send_box(mk_box(160, 0, 160, 160), 1'b0);               // touching edge
        send_box(mk_box(-32768, -32768, 0, 0), 1'b0);           // empty box
        send_box(mk_box(-32768, -32768, 0, 0), 1'b0);           // empty vs empty
        send_box(mk_box(32767, 32767, 32767, 32767), 1'b0);     // far corner
        send_box(mk_box(32767, 32767, 32767, 32767), 1'b0);
        send_box(mk_box(69, 0, 160, 160), 1'b0);                // just under 0.4
        send_box(mk_box(68, 0, 160, 160), 1'b0);                // just over 0.4
        send_box(mk_box(-100, -100, 32767, 0), 1'b0);
        send_box(mk_box(100, 100, 0, 32767), 1'b0);
        send_box(mk_box(-32768, 0, 32767, 32767), 1'b0);        // huge box
        send_box(mk_box(-16384, 16384, 16, 16), 1'b0);          // tiny inside huge
        send_box(mk_box(0, 0, 160, 160), 1'b1);
        send_box(mk_box(0, 0, 160, 160), 1'b1);                 // store emptied
    endtask

    task automatic test_threshold_extremes();
        // zero threshold: any overlap at all suppresses
        write_threshold('0);
        send_box(mk_box(0, 0, 160, 160), 1'b0);
        send_box(mk_box(159, 159, 160, 160), 1'b0);
        send_box(mk_box(160, 160, 16, 16), 1'b0);
        send_box(mk_box(0, 0, 0, 0), 1'b1);
        // full-scale threshold: only an exact copy suppresses
        write_threshold('1);
        send_box(mk_box(0, 0, 160, 160), 1'b0);
        send_box(mk_box(0, 0, 160, 160), 1'b0);
        send_box(mk_box(0, 0, 160, 161), 1'b0);
        send_box(mk_box(1, 0, 160, 160), 1'b0);
        send_box(mk_box(0, 0, 160, 161), 1'b1);
    endtask

    // more survivors than the store holds in one frame
    task automatic test_store_full();
        write_threshold(THRESH_RESET);
        for (int i = 0; i < MAX_KEPT + 6; i++)
            send_box(mk_box(-32768 + i * 900, 0, 256, 256), 1'b0);
        send_box(mk_box(-32768, 0, 256, 256), 1'b0);                  // stored, dropped
        send_box(mk_box(-32768 + 65 * 900, 0, 256, 256), 1'b0);       // never stored
        send_box(mk_box(-32768 + 5 * 900, 5000, 256, 256), 1'b1);
    endtask

    // random frames: clustered boxes with some noise, or widely spread small boxes
    task automatic test_random_frames(input int n_items, input logic [THRESH_W-1:0] thr);
        int sent, len, sel, ncl, k, jx, jw;
        bit spread;
        int cx [6];
        int cy [6];
        int cw [6];
        int ch [6];
        write_threshold(thr);
        sent = 0;
        while (sent < n_items) begin
            sel = $urandom_range(0, 19);
            if (sel < 14) len = $urandom_range(1, 24);
            else if (sel < 18) len = $urandom_range(25, 90);
            else len = 1;
            spread = ($urandom_range(0, 3) == 0);
            ncl    = $urandom_range(1, 6);
            for (int c = 0; c < ncl; c++) begin
                cx[c] = $urandom_range(0, 65535) - 32768;
                cy[c] = $urandom_range(0, 65535) - 32768;
                cw[c] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                    : $urandom_range(16, 4096);
                ch[c] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                    : $urandom_range(16, 4096);
            end
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_box(mk_box($urandom, $urandom, $urandom, $urandom), j == len - 1);
                end else if (spread) begin
                    send_box(mk_box($urandom, $urandom,
                                    ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1500),
                                    $urandom_range(0, 1500)), j == len - 1);
                end else begin
                    k  = $urandom_range(0, ncl - 1);
                    jx = cw[k] / 4 + 1;
                    jw = cw[k] / 8 + 1;
                    send_box(mk_box(cx[k] + $urandom_range(0, 2 * jx) - jx,
                                    cy[k] + $urandom_range(0, 2 * jx) - jx,
                                    cw[k] + $urandom_range(0, 2 * jw) - jw,
                                    ch[k] + $urandom_range(0, 2 * jw) - jw), j == len - 1);
                end
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_box_left      = '0;
        i_box_top       = '0;
        i_box_width     = '0;
        i_box_height    = '0;
        i_last_in_frame = 1'b0;
        i_ready         = 1'b1;
        stall_left      = 0;
        idling          = 1'b1;
        errors          = 0;
        items_sent      = 0;
        n_kept          = 0;
        n_dropped       = 0;
        n_full          = 0;
        n_frames        = 0;
        kept_n          = 0;
        cand_no         = 0;
        thresh_q16      = THRESH_RESET;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_boxes();
        test_threshold_extremes();
        test_store_full();
        test_random_frames(90, THRESH_RESET);
        test_random_frames(90, '0);
        test_random_frames(90, '1);
        test_random_frames(90, 16'($urandom));
        test_random_frames(90, 16'($urandom_range(40000, 60000)));
        idling = 1'b0;
        test_random_frames(100, 16'($urandom_range(13000, 39000)));

        drain_results();
        repeat (MAX_KEPT + 16) @(posedge i_clk);
        $display("ran %0d candidates in %0d frames over six thresholds plus extremes",
                 items_sent, n_frames);
        $display("verdicts: %0d kept, %0d dropped, %0d kept with full store, %0d errors",
                 n_kept, n_dropped, n_full, errors);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // run limit
    initial begin
        #8_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
